// ===== src/stp_pkg.sv =====
package stp_pkg;

    localparam int PEER_SLOTS    = 4;
    localparam int UNKNOWN_SLOTS = 16;
    localparam int NUM_KNOWN     = 22;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);

    localparam logic [15:0] TYPE_FINGERPRINT = 16'h8028;
    localparam logic [15:0] TYPE_INTEGRITY   = 16'h0008;
    localparam logic [15:0] TYPE_PEER        = 16'h0012;
    localparam logic [15:0] TYPE_OPT_LIMIT   = 16'h7fff;
    localparam logic [15:0] HEADER_BYTES     = 16'd20;
    localparam logic [4:0]  KIND_UNKNOWN     = 5'd22;
    localparam logic [4:0]  CAP_RESET        = 5'd16;

    localparam logic        REC_ATTR    = 1'b0;
    localparam logic        REC_SUMMARY = 1'b1;

    localparam logic [15:0] KNOWN_TYPES [NUM_KNOWN] = '{
        16'h0001, 16'h0020, 16'h8023, 16'h0015, 16'h0014, 16'h0006,
        16'h0009, 16'h000A, 16'h0008, 16'h8028, 16'h8022, 16'h000C,
        16'h000D, 16'h0012, 16'h0013, 16'h0016, 16'h0018, 16'h0019,
        16'h001A, 16'h0022, 16'h0017, 16'h002A
    };

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] frame_len;
        logic        end_of_frame;
    } t_in_word;

    typedef struct packed {
        logic        record_kind;
        logic [4:0]  attr_kind;
        logic [15:0] attr_type;
        logic [15:0] attr_offset;
        logic [15:0] value_len;
        logic [15:0] msg_type;
        logic        status;
        logic [4:0]  unknown_count;
        logic        peer_overflow;
        logic        last_record;
    } t_out_word;

    typedef struct packed {
        logic        attr_v;
        logic [4:0]  attr_kind;
        logic [15:0] attr_type;
        logic [15:0] attr_off;
        logic [15:0] value_len;
        logic        sum_v;
        logic [15:0] msg_type;
        logic        status;
        logic [4:0]  unk_cnt;
        logic        peer_ovf;
    } t_event;

    function automatic logic [5:0] classify(input logic [15:0] code);
        logic [5:0] res;
        res = 6'd0;
        for (int k = 0; k < NUM_KNOWN; k++) begin
            if (KNOWN_TYPES[k] == code) begin
                res = {1'b1, 5'(k)};
            end
        end
        return res;
    endfunction

endpackage

// ===== src/stp_front.sv =====
module stp_front
    import stp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic [4:0] i_cfg_wdata,
    input  logic     i_in_valid,
    input  t_in_word i_in_word,
    input  logic     i_space,
    output logic     o_in_ready,
    output logic     o_push,
    output t_event   o_event
);

    logic [4:0]         r_cap;
    logic [15:0]        r_pos,   n_pos;
    logic signed [17:0] r_rem,   n_rem;
    logic [16:0]        r_next,  n_next;
    logic [31:0]        r_shift, n_shift;
    logic [15:0]        r_mtype, n_mtype;
    logic               r_integ, n_integ;
    logic               r_fp,    n_fp;
    logic               r_done,  n_done;
    logic               r_err,   n_err;
    logic [4:0]         r_peer,  n_peer;
    logic [4:0]         r_unk,   n_unk;
    logic               r_ovf,   n_ovf;

    logic        accept;
    logic [15:0] mlen;
    logic [15:0] htype;
    logic [15:0] hlen;
    logic [5:0]  cls;
    logic [16:0] span;
    logic [4:0]  cap_eff;
    t_event      ev;

    assign accept     = i_in_valid && i_space;
    assign o_in_ready = i_space;
    assign cap_eff    = (r_cap > 5'(UNKNOWN_SLOTS)) ? 5'(UNKNOWN_SLOTS) : r_cap;

    always_comb begin
        n_shift = {r_shift[23:0], i_in_word.data_byte};
        n_pos   = r_pos;
        n_rem   = r_rem;
        n_next  = r_next;
        n_mtype = r_mtype;
        n_integ = r_integ;
        n_fp    = r_fp;
        n_done  = r_done;
        n_err   = r_err;
        n_peer  = r_peer;
        n_unk   = r_unk;
        n_ovf   = r_ovf;
        mlen    = n_shift[15:0];
        htype   = n_shift[31:16];
        hlen    = n_shift[15:0];
        cls     = classify(htype);
        span    = ({1'b0, hlen} + 17'd7) & 17'h1fffc;
        ev      = '0;

        if (r_pos == 16'd1) begin
            n_mtype = n_shift[15:0];
        end else if (r_pos == 16'd3) begin
            if (i_in_word.frame_len < HEADER_BYTES
                || ({1'b0, mlen} + {1'b0, HEADER_BYTES}) > {1'b0, i_in_word.frame_len}
                || mlen[1:0] != 2'b00) begin
                n_err  = 1'b1;
                n_done = 1'b1;
            end else begin
                n_rem = signed'({2'b00, mlen});
                if (mlen < 16'd4) begin
                    n_done = 1'b1;
                end
            end
        end else if (r_pos >= HEADER_BYTES && !r_done
                     && {2'b00, r_pos} == ({1'b0, r_next} + 18'd3)) begin
            if (r_fp || (r_integ && htype != TYPE_FINGERPRINT)) begin
                n_done = 1'b1;
            end else begin
                ev.attr_type = htype;
                ev.attr_off  = r_next[15:0];
                ev.value_len = hlen;
                if (cls[5]) begin
                    ev.attr_kind = cls[4:0];
                    if (htype == TYPE_PEER) begin
                        if (r_peer < 5'(PEER_SLOTS)) begin
                            n_peer    = r_peer + 5'd1;
                            ev.attr_v = 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end else begin
                        ev.attr_v = 1'b1;
                        if (htype == TYPE_INTEGRITY) begin
                            n_integ = 1'b1;
                        end else if (htype == TYPE_FINGERPRINT) begin
                            n_fp = 1'b1;
                        end
                    end
                end else if (htype <= TYPE_OPT_LIMIT) begin
                    ev.attr_kind = KIND_UNKNOWN;
                    if (r_unk < cap_eff) begin
                        n_unk     = r_unk + 5'd1;
                        ev.attr_v = 1'b1;
                    end
                end
                n_rem  = r_rem - signed'({1'b0, span});
                n_next = r_next + span;
                if (n_rem < 18'sd4) begin
                    n_done = 1'b1;
                end
            end
        end

        if (r_pos != 16'hffff) begin
            n_pos = r_pos + 16'd1;
        end

        if (i_in_word.end_of_frame) begin
            ev.sum_v    = 1'b1;
            ev.msg_type = n_mtype;
            ev.status   = n_err || (r_pos < 16'd19);
            ev.unk_cnt  = n_unk;
            ev.peer_ovf = n_ovf;
            n_pos   = '0;
            n_rem   = '0;
            n_next  = 17'(HEADER_BYTES);
            n_shift = '0;
            n_mtype = '0;
            n_integ = 1'b0;
            n_fp    = 1'b0;
            n_done  = 1'b0;
            n_err   = 1'b0;
            n_peer  = '0;
            n_unk   = '0;
            n_ovf   = 1'b0;
        end
    end

    assign o_event = ev;
    assign o_push  = accept && (ev.attr_v || ev.sum_v);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_rem   <= '0;
            r_next  <= 17'(HEADER_BYTES);
            r_shift <= '0;
            r_mtype <= '0;
            r_integ <= 1'b0;
            r_fp    <= 1'b0;
            r_done  <= 1'b0;
            r_err   <= 1'b0;
            r_peer  <= '0;
            r_unk   <= '0;
            r_ovf   <= 1'b0;
        end else if (accept) begin
            r_pos   <= n_pos;
            r_rem   <= n_rem;
            r_next  <= n_next;
            r_shift <= n_shift;
            r_mtype <= n_mtype;
            r_integ <= n_integ;
            r_fp    <= n_fp;
            r_done  <= n_done;
            r_err   <= n_err;
            r_peer  <= n_peer;
            r_unk   <= n_unk;
            r_ovf   <= n_ovf;
        end
    end

`ifndef SYNTHESIS
    a_unk_within_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_unk <= 5'(UNKNOWN_SLOTS))
        else $error("unknown count beyond slot limit");
    a_peer_within_slots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_peer <= 5'(PEER_SLOTS))
        else $error("peer count beyond slot limit");
`endif

endmodule

// ===== src/stp_fifo.sv =====
module stp_fifo
    import stp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_event i_data,
    input  logic   i_pop,
    output t_event o_head,
    output logic   o_empty,
    output logic   o_space
);

    t_event               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr;
    logic [FIFO_AW-1:0]   r_rd;
    logic [FIFO_CW-1:0]   r_cnt;

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_cnt == '0);
    assign o_space = (r_cnt != FIFO_CW'(FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_space)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
`endif

endmodule

// ===== src/stp_back.sv =====
module stp_back
    import stp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_event    i_head,
    input  logic      i_empty,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic      r_phase;
    logic      r_valid;
    t_out_word r_word;
    t_out_word n_word;
    logic      load;
    logic      take_attr;
    logic      last_of_event;

    assign load          = !i_empty && (!r_valid || i_out_ready);
    assign take_attr     = !r_phase && i_head.attr_v;
    assign last_of_event = !take_attr || !i_head.sum_v;
    assign o_pop         = load && last_of_event;

    always_comb begin
        n_word = '0;
        if (take_attr) begin
            n_word.record_kind = REC_ATTR;
            n_word.attr_kind   = i_head.attr_kind;
            n_word.attr_type   = i_head.attr_type;
            n_word.attr_offset = i_head.attr_off;
            n_word.value_len   = i_head.value_len;
        end else begin
            n_word.record_kind   = REC_SUMMARY;
            n_word.msg_type      = i_head.msg_type;
            n_word.status        = i_head.status;
            n_word.unknown_count = i_head.unk_cnt;
            n_word.peer_overflow = i_head.peer_ovf;
            n_word.last_record   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
            if (load) begin
                r_phase <= !last_of_event;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word <= n_word;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_word  = r_word;

`ifndef SYNTHESIS
    a_phase_has_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> (!i_empty && i_head.sum_v))
        else $error("second half of a word pair without a summary");
    a_attr_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_word.record_kind == REC_ATTR) |-> !r_word.last_record)
        else $error("attribute word marked as last");
`endif

endmodule

// ===== src/stun_turn_attribute_parser_core.sv =====
// Takes one message byte per cycle when the record queue has room.
// A record enters the queue when the byte that causes it is accepted, then the output
// register; a summary from the same byte as an attribute record follows that record.
// Records leave at one per cycle while i_out_ready is high; a four-entry queue sits
// between parser and output. Synchronous active-low reset clears the parser state,
// queue pointers and output valid flag, and sets unknown-attribute capacity to 16.
module stun_turn_attribute_parser_core
    import stp_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_we,
    input  logic [4:0] i_cfg_wdata,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    logic   push;
    logic   pop;
    logic   empty;
    logic   space;
    t_event ev;
    t_event head;

    stp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .i_space     (space),
        .o_in_ready  (o_in_ready),
        .o_push      (push),
        .o_event     (ev)
    );

    stp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (ev),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_space (space)
    );

    stp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

endmodule
